// ===== rtl/core/tlic_pkg.sv =====
// shared constants for the two-level inclusive cache tag block
// no dependencies; used by two_level_inclusive_cache_tags and its testbench
package tlic_pkg;

	// default geometry
	localparam int NEAR_SETS_DEF   = 64;
	localparam int NEAR_WAYS_DEF   = 2;
	localparam int FAR_SETS_DEF    = 256;
	localparam int FAR_WAYS_DEF    = 8;
	localparam int OFFSET_BITS_DEF = 6;

	// address width of an access
	localparam int ADDR_W = 32;

	// access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// eviction report codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_CLEAN = 2'd1;
	localparam logic [1:0] EV_DIRTY = 2'd2;

	// victim lfsr, galois form
	localparam logic [15:0] LFSR_SEED = 16'h0001;
	localparam logic [15:0] LFSR_MASK = 16'hB400;

endpackage

// ===== rtl/core/tlic_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// depends on nothing; instantiated by two_level_inclusive_cache_tags
module tlic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/two_level_inclusive_cache_tags.sv =====
// top level: tag, state and recency control of an inclusive two-level cache
// depends on tlic_pkg and tlic_ram (one ram per level, one row per set)
//
//   channel   signals                         direction  word
//   in        in_valid in_stall opcode address  in        one access
//   out       out_valid out_stall l1_hit l2_hit out       one result
//             l1_evict l2_evict back_invalidate
//   cfg       cfg_valid cfg_ready cfg_data      in        replace_random
//
// an L1 miss takes more steps than an L1 hit, each step one read-modify-write
// of a set row in a ram with a registered read. after reset a clearing pass
// zeroes both rams; in_stall is high during it, configuration writes are
// taken anyway. a result waiting on out_stall does not block the next access
// from entering.
module two_level_inclusive_cache_tags #(
	parameter int NEAR_SETS   = tlic_pkg::NEAR_SETS_DEF,
	parameter int NEAR_WAYS   = tlic_pkg::NEAR_WAYS_DEF,
	parameter int FAR_SETS    = tlic_pkg::FAR_SETS_DEF,
	parameter int FAR_WAYS    = tlic_pkg::FAR_WAYS_DEF,
	parameter int OFFSET_BITS = tlic_pkg::OFFSET_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [tlic_pkg::ADDR_W-1:0] address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        l1_hit,
	output logic                        l2_hit,
	output logic [1:0]                  l1_evict,
	output logic [1:0]                  l2_evict,
	output logic [1:0]                  back_invalidate,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data
);

	localparam int LINE_W = tlic_pkg::ADDR_W - OFFSET_BITS;
	localparam int NSB    = (NEAR_SETS > 1) ? $clog2(NEAR_SETS) : 1;
	localparam int FSB    = (FAR_SETS > 1) ? $clog2(FAR_SETS) : 1;
	localparam int NTW    = LINE_W - NSB;
	localparam int FTW    = LINE_W - FSB;
	localparam int NAW    = (NEAR_WAYS > 1) ? $clog2(NEAR_WAYS) : 1;
	localparam int FAW    = (FAR_WAYS > 1) ? $clog2(FAR_WAYS) : 1;
	localparam int MAXR   = (NEAR_SETS > FAR_SETS) ? NEAR_SETS : FAR_SETS;
	localparam int CW     = $clog2(MAXR + 1);

	typedef struct packed {
		logic [NEAR_WAYS-1:0][NTW-1:0] tag;
		logic [NEAR_WAYS-1:0][NAW-1:0] age;
		logic [NEAR_WAYS-1:0]          dirty;
		logic [NEAR_WAYS-1:0]          valid;
	} near_row_t;

	typedef struct packed {
		logic [FAR_WAYS-1:0][FTW-1:0] tag;
		logic [FAR_WAYS-1:0][FAW-1:0] age;
		logic [FAR_WAYS-1:0]          dirty;
		logic [FAR_WAYS-1:0]          valid;
	} far_row_t;

	localparam int NRW = $bits(near_row_t);
	localparam int FRW = $bits(far_row_t);

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_LOOK, S_BINV, S_NFILL, S_MARK, S_RESP
	} state_t;

	state_t            state_q, state_d;
	logic [CW-1:0]     clr_q;
	logic              rand_q;
	logic [15:0]       lfsr_q;
	logic              op_q;
	logic [NSB-1:0]    nset_q;
	logic [NTW-1:0]    ntag_q;
	logic [FSB-1:0]    fset_q;
	logic [FTW-1:0]    ftag_q;
	near_row_t         nrow_q;
	logic [NSB-1:0]    vs_q;
	logic [NTW-1:0]    vt_q;
	logic              fvdirty_q;
	logic [FSB-1:0]    ms_q;
	logic [FTW-1:0]    mt_q;
	logic              l1h_q, l2h_q;
	logic [1:0]        l1e_q, l2e_q, bi_q;
	logic              out_valid_q;
	logic              o_l1h_q, o_l2h_q;
	logic [1:0]        o_l1e_q, o_l2e_q, o_bi_q;

	// ram ports
	logic              n_we, f_we;
	logic [NSB-1:0]    n_waddr, n_raddr;
	logic [FSB-1:0]    f_waddr, f_raddr;
	logic [NRW-1:0]    n_wdata, n_rdata;
	logic [FRW-1:0]    f_wdata, f_rdata;

	tlic_ram #(.WIDTH(NRW), .DEPTH(NEAR_SETS)) u_near_ram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rdata)
	);

	tlic_ram #(.WIDTH(FRW), .DEPTH(FAR_SETS)) u_far_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	logic [LINE_W-1:0] in_line;
	assign in_line = address[tlic_pkg::ADDR_W-1:OFFSET_BITS];

	// lookup step: L1 hit check, L2 hit check or L2 fill with victim
	near_row_t         nd, n_hitrow;
	far_row_t          fd, f_new;
	logic              n_hit, f_hit, f_full, f_vvalid;
	logic [FAW:0]      f_a;
	logic [FAW-1:0]    f_w;
	logic [LINE_W-1:0] f_vline;

	always_comb begin
		logic [NAW:0] na;
		logic [NAW-1:0] nw;
		logic f_inv;
		nd       = near_row_t'(n_rdata);
		fd       = far_row_t'(f_rdata);
		n_hit    = 1'b0;
		nw       = '0;
		for (int i = 0; i < NEAR_WAYS; i++) begin
			if (!n_hit && nd.valid[i] && nd.tag[i] == ntag_q) begin
				n_hit = 1'b1;
				nw    = NAW'(i);
			end
		end
		// make the hit way most recent
		n_hitrow = nd;
		na       = {1'b0, nd.age[nw]};
		for (int i = 0; i < NEAR_WAYS; i++) begin
			if (NAW'(i) != nw && nd.valid[i] && {1'b0, nd.age[i]} < na) begin
				n_hitrow.age[i] = nd.age[i] + 1'b1;
			end
		end
		n_hitrow.age[nw] = '0;
		if (op_q == tlic_pkg::OP_WRITE) begin
			n_hitrow.dirty[nw] = 1'b1;
		end

		f_hit = 1'b0;
		f_w   = '0;
		for (int i = 0; i < FAR_WAYS; i++) begin
			if (!f_hit && fd.valid[i] && fd.tag[i] == ftag_q) begin
				f_hit = 1'b1;
				f_w   = FAW'(i);
			end
		end
		// victim: first invalid way, else random or oldest
		f_full = &fd.valid;
		f_inv  = 1'b0;
		if (!f_hit) begin
			for (int i = 0; i < FAR_WAYS; i++) begin
				if (!f_inv && !fd.valid[i]) begin
					f_inv = 1'b1;
					f_w   = FAW'(i);
				end
			end
			if (f_full) begin
				if (rand_q) begin
					f_w = FAW'(lfsr_q % 16'(FAR_WAYS));
				end else begin
					for (int i = 0; i < FAR_WAYS; i++) begin
						if (fd.age[i] == FAW'(FAR_WAYS - 1)) begin
							f_w = FAW'(i);
						end
					end
				end
			end
		end
		f_vvalid = !f_hit && fd.valid[f_w];
		f_vline  = {fd.tag[f_w], fset_q};
		// touch the chosen way, then fill on a miss
		f_new = fd;
		f_a   = fd.valid[f_w] ? {1'b0, fd.age[f_w]} : (FAW + 1)'(FAR_WAYS);
		for (int i = 0; i < FAR_WAYS; i++) begin
			if (FAW'(i) != f_w && fd.valid[i] && {1'b0, fd.age[i]} < f_a) begin
				f_new.age[i] = fd.age[i] + 1'b1;
			end
		end
		f_new.age[f_w] = '0;
		if (!f_hit) begin
			f_new.tag[f_w]   = ftag_q;
			f_new.valid[f_w] = 1'b1;
			f_new.dirty[f_w] = 1'b0;
		end
	end

	// back-invalidate step: drop the L1 copy of the L2 victim
	near_row_t bd, b_new;
	logic      b_hit;
	logic [NAW-1:0] b_w;

	always_comb begin
		bd    = near_row_t'(n_rdata);
		b_hit = 1'b0;
		b_w   = '0;
		for (int i = 0; i < NEAR_WAYS; i++) begin
			if (!b_hit && bd.valid[i] && bd.tag[i] == vt_q) begin
				b_hit = 1'b1;
				b_w   = NAW'(i);
			end
		end
		b_new = bd;
		for (int i = 0; i < NEAR_WAYS; i++) begin
			if (NAW'(i) != b_w && bd.valid[i] && bd.age[i] > bd.age[b_w]) begin
				b_new.age[i] = bd.age[i] - 1'b1;
			end
		end
		b_new.valid[b_w] = 1'b0;
		b_new.dirty[b_w] = 1'b0;
		b_new.age[b_w]   = '0;
	end

	// L1 fill step on the current set row
	near_row_t         r_new;
	logic              r_full, r_vvalid, r_vdirty;
	logic [NAW-1:0]    r_w;
	logic [LINE_W-1:0] r_vline;

	always_comb begin
		logic r_inv;
		logic [NAW:0] ra;
		r_full = &nrow_q.valid;
		r_inv  = 1'b0;
		r_w    = '0;
		for (int i = 0; i < NEAR_WAYS; i++) begin
			if (!r_inv && !nrow_q.valid[i]) begin
				r_inv = 1'b1;
				r_w   = NAW'(i);
			end
		end
		if (r_full) begin
			if (rand_q) begin
				r_w = NAW'(lfsr_q % 16'(NEAR_WAYS));
			end else begin
				for (int i = 0; i < NEAR_WAYS; i++) begin
					if (nrow_q.age[i] == NAW'(NEAR_WAYS - 1)) begin
						r_w = NAW'(i);
					end
				end
			end
		end
		r_vvalid = nrow_q.valid[r_w];
		r_vdirty = nrow_q.valid[r_w] && nrow_q.dirty[r_w];
		r_vline  = {nrow_q.tag[r_w], nset_q};
		r_new    = nrow_q;
		ra       = nrow_q.valid[r_w] ? {1'b0, nrow_q.age[r_w]} : (NAW + 1)'(NEAR_WAYS);
		for (int i = 0; i < NEAR_WAYS; i++) begin
			if (NAW'(i) != r_w && nrow_q.valid[i] && {1'b0, nrow_q.age[i]} < ra) begin
				r_new.age[i] = nrow_q.age[i] + 1'b1;
			end
		end
		r_new.age[r_w]   = '0;
		r_new.tag[r_w]   = ntag_q;
		r_new.valid[r_w] = 1'b1;
		r_new.dirty[r_w] = op_q;
	end

	// dirty mark step on the L2 copy of a dirty L1 victim
	far_row_t md, m_new;
	logic     m_hit;

	always_comb begin
		md    = far_row_t'(f_rdata);
		m_hit = 1'b0;
		m_new = md;
		for (int i = 0; i < FAR_WAYS; i++) begin
			if (!m_hit && md.valid[i] && md.tag[i] == mt_q) begin
				m_hit          = 1'b1;
				m_new.dirty[i] = 1'b1;
			end
		end
	end

	logic [15:0] lfsr_next;
	assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? tlic_pkg::LFSR_MASK : 16'h0000);

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// ram control and next state
	always_comb begin
		state_d = state_q;
		n_we    = 1'b0;
		f_we    = 1'b0;
		n_waddr = nset_q;
		f_waddr = fset_q;
		n_wdata = NRW'(r_new);
		f_wdata = FRW'(f_new);
		n_raddr = in_line[NSB-1:0];
		f_raddr = in_line[FSB-1:0];
		case (state_q)
			S_CLR: begin
				n_we    = clr_q < CW'(NEAR_SETS);
				f_we    = clr_q < CW'(FAR_SETS);
				n_waddr = clr_q[NSB-1:0];
				f_waddr = clr_q[FSB-1:0];
				n_wdata = '0;
				f_wdata = '0;
				if (clr_q == CW'(MAXR - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				n_raddr = f_vline[NSB-1:0];
				if (n_hit) begin
					n_we    = 1'b1;
					n_wdata = NRW'(n_hitrow);
					state_d = S_RESP;
				end else begin
					f_we    = 1'b1;
					state_d = f_vvalid ? S_BINV : S_NFILL;
				end
			end
			S_BINV: begin
				n_we    = b_hit;
				n_waddr = vs_q;
				n_wdata = NRW'(b_new);
				state_d = S_NFILL;
			end
			S_NFILL: begin
				n_we    = 1'b1;
				f_raddr = r_vline[FSB-1:0];
				state_d = r_vdirty ? S_MARK : S_RESP;
			end
			S_MARK: begin
				f_we    = m_hit;
				f_waddr = ms_q;
				f_wdata = FRW'(m_new);
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, access registers and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			rand_q      <= 1'b0;
			lfsr_q      <= tlic_pkg::LFSR_SEED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				rand_q <= cfg_data;
			end
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			// result word valid: set on response, cleared when taken
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= opcode;
						nset_q <= in_line[NSB-1:0];
						ntag_q <= in_line[LINE_W-1:NSB];
						fset_q <= in_line[FSB-1:0];
						ftag_q <= in_line[LINE_W-1:FSB];
					end
				end
				S_LOOK: begin
					nrow_q    <= nd;
					l1h_q     <= n_hit;
					l2h_q     <= !n_hit && f_hit;
					l1e_q     <= tlic_pkg::EV_NONE;
					bi_q      <= tlic_pkg::EV_NONE;
					l2e_q     <= tlic_pkg::EV_NONE;
					vs_q      <= f_vline[NSB-1:0];
					vt_q      <= f_vline[LINE_W-1:NSB];
					fvdirty_q <= fd.dirty[f_w];
					if (!n_hit && !f_hit && f_full && rand_q) begin
						lfsr_q <= lfsr_next;
					end
				end
				S_BINV: begin
					if (b_hit) begin
						bi_q  <= bd.dirty[b_w] ? tlic_pkg::EV_DIRTY : tlic_pkg::EV_CLEAN;
						l2e_q <= (fvdirty_q || bd.dirty[b_w]) ?
							tlic_pkg::EV_DIRTY : tlic_pkg::EV_CLEAN;
						if (vs_q == nset_q) begin
							nrow_q <= b_new;
						end
					end else begin
						l2e_q <= fvdirty_q ? tlic_pkg::EV_DIRTY : tlic_pkg::EV_CLEAN;
					end
				end
				S_NFILL: begin
					l1e_q <= !r_vvalid ? tlic_pkg::EV_NONE :
						(r_vdirty ? tlic_pkg::EV_DIRTY : tlic_pkg::EV_CLEAN);
					ms_q  <= r_vline[FSB-1:0];
					mt_q  <= r_vline[LINE_W-1:FSB];
					if (r_full && rand_q) begin
						lfsr_q <= lfsr_next;
					end
				end
				S_RESP: begin
					if (out_free) begin
						o_l1h_q     <= l1h_q;
						o_l2h_q     <= l2h_q;
						o_l1e_q     <= l1e_q;
						o_l2e_q     <= l2e_q;
						o_bi_q      <= bi_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ports
	assign in_stall        = (state_q != S_IDLE);
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign l1_hit          = o_l1h_q;
	assign l2_hit          = o_l2h_q;
	assign l1_evict        = o_l1e_q;
	assign l2_evict        = o_l2e_q;
	assign back_invalidate = o_bi_q;

endmodule

// ===== tb/sv/two_level_inclusive_cache_tags_tb.sv =====
// testbench for two_level_inclusive_cache_tags: random and directed accesses
// checked against a behavioral tag/recency model; depends on tlic_pkg and two_level_inclusive_cache_tags
`timescale 1ns / 1ps

module two_level_inclusive_cache_tags_tb;

	localparam int NSETS = tlic_pkg::NEAR_SETS_DEF;
	localparam int NWAYS = tlic_pkg::NEAR_WAYS_DEF;
	localparam int FSETS = tlic_pkg::FAR_SETS_DEF;
	localparam int FWAYS = tlic_pkg::FAR_WAYS_DEF;
	localparam int OFFB  = tlic_pkg::OFFSET_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic        op;
		logic [31:0] addr;
	} access_t;

	typedef struct packed {
		logic       l1h;
		logic       l2h;
		logic [1:0] l1e;
		logic [1:0] l2e;
		logic [1:0] binv;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall, opcode;
	logic [31:0] address;
	logic out_valid, out_stall;
	logic l1_hit, l2_hit;
	logic [1:0] l1_evict, l2_evict, back_invalidate;
	logic cfg_valid, cfg_ready, cfg_data;

	two_level_inclusive_cache_tags u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .address(address),
		.out_valid(out_valid), .out_stall(out_stall), .l1_hit(l1_hit), .l2_hit(l2_hit),
		.l1_evict(l1_evict), .l2_evict(l2_evict), .back_invalidate(back_invalidate),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// model state
	logic [31:0] n_tag[NSETS*NWAYS];
	bit          n_val[NSETS*NWAYS];
	bit          n_dty[NSETS*NWAYS];
	int          n_age[NSETS*NWAYS];
	logic [31:0] f_tag[FSETS*FWAYS];
	bit          f_val[FSETS*FWAYS];
	bit          f_dty[FSETS*FWAYS];
	int          f_age[FSETS*FWAYS];
	logic [15:0] lfsr;
	bit          rand_policy;

	access_t  pending_words[$];
	outcome_t expected_results[$];
	int  errors;
	int  idle_cycles;
	bit  quiet;
	bit  send_pause;
	bit  in_taken;
	bit  hold_req;
	bit  hold_done;
	int  hold_cnt;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// way search, -1 when absent
	function automatic int near_find(int base, logic [31:0] tag);
		for (int w = 0; w < NWAYS; w++)
			if (n_val[base+w] && n_tag[base+w] == tag) return w;
		return -1;
	endfunction

	function automatic int far_find(int base, logic [31:0] tag);
		for (int w = 0; w < FWAYS; w++)
			if (f_val[base+w] && f_tag[base+w] == tag) return w;
		return -1;
	endfunction

	// recency update for near (lvl 0) or far (lvl 1)
	task automatic promote(bit lvl, int base, int w);
		int ways, a;
		ways = lvl ? FWAYS : NWAYS;
		if (lvl) begin
			a = f_val[base+w] ? f_age[base+w] : ways;
			for (int i = 0; i < ways; i++)
				if (i != w && f_val[base+i] && f_age[base+i] < a) f_age[base+i]++;
			f_age[base+w] = 0;
		end else begin
			a = n_val[base+w] ? n_age[base+w] : ways;
			for (int i = 0; i < ways; i++)
				if (i != w && n_val[base+i] && n_age[base+i] < a) n_age[base+i]++;
			n_age[base+w] = 0;
		end
	endtask

	task automatic choose_victim(bit lvl, int base, output int v);
		int ways;
		ways = lvl ? FWAYS : NWAYS;
		for (int w = 0; w < ways; w++)
			if (!(lvl ? f_val[base+w] : n_val[base+w])) begin
				v = w;
				return;
			end
		if (rand_policy) begin
			v = lfsr % ways;
			lfsr = (lfsr >> 1) ^ (lfsr[0] ? tlic_pkg::LFSR_MASK : 16'h0);
			return;
		end
		v = 0;
		for (int w = 1; w < ways; w++)
			if ((lvl ? f_age[base+w] : n_age[base+w]) > (lvl ? f_age[base+v] : n_age[base+v]))
				v = w;
	endtask

	// apply one access to the model, return the outcome
	task automatic cache_access(access_t acc, output outcome_t r);
		logic [31:0] line, vline;
		int nset, fset, nb, fb, w, fw, v, vs, cw, ci;
		logic [31:0] ntag, ftag;
		bit dirty;
		line = acc.addr >> OFFB;
		nset = line % NSETS; ntag = line / NSETS;
		fset = line % FSETS; ftag = line / FSETS;
		nb = nset * NWAYS; fb = fset * FWAYS;
		r = '0;
		w = near_find(nb, ntag);
		if (w >= 0) begin
			r.l1h = 1'b1;
			promote(0, nb, w);
			if (acc.op == tlic_pkg::OP_WRITE) n_dty[nb+w] = 1'b1;
			return;
		end
		fw = far_find(fb, ftag);
		if (fw >= 0) begin
			r.l2h = 1'b1;
			promote(1, fb, fw);
		end else begin
			choose_victim(1, fb, v);
			if (f_val[fb+v]) begin
				vline = f_tag[fb+v] * FSETS + fset;
				vs = vline % NSETS;
				cw = near_find(vs * NWAYS, vline / NSETS);
				dirty = f_dty[fb+v];
				if (cw >= 0) begin
					ci = vs * NWAYS + cw;
					r.binv = n_dty[ci] ? tlic_pkg::EV_DIRTY : tlic_pkg::EV_CLEAN;
					if (n_dty[ci]) dirty = 1'b1;
					// drop the back-invalidated copy
					for (int i = 0; i < NWAYS; i++)
						if (i != cw && n_val[vs*NWAYS+i] && n_age[vs*NWAYS+i] > n_age[ci])
							n_age[vs*NWAYS+i]--;
					n_val[ci] = 0; n_dty[ci] = 0; n_age[ci] = 0;
				end
				r.l2e = dirty ? tlic_pkg::EV_DIRTY : tlic_pkg::EV_CLEAN;
			end
			promote(1, fb, v);
			f_tag[fb+v] = ftag; f_val[fb+v] = 1; f_dty[fb+v] = 0;
		end
		choose_victim(0, nb, v);
		if (n_val[nb+v]) begin
			r.l1e = n_dty[nb+v] ? tlic_pkg::EV_DIRTY : tlic_pkg::EV_CLEAN;
			if (n_dty[nb+v]) begin
				vline = n_tag[nb+v] * NSETS + nset;
				vs = vline % FSETS;
				fw = far_find(vs * FWAYS, vline / FSETS);
				if (fw >= 0) f_dty[vs*FWAYS+fw] = 1'b1;
			end
		end
		promote(0, nb, v);
		n_tag[nb+v] = ntag; n_val[nb+v] = 1; n_dty[nb+v] = (acc.op == tlic_pkg::OP_WRITE);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// append one access word to the send queue
	task automatic queue_word(access_t a);
		pending_words = {pending_words, a};
	endtask

	// acceptance of the word currently offered
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
	end

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= tlic_pkg::OP_READ;
			address <= '0;
		end else if (!in_valid || in_taken) begin
			if (pending_words.size() != 0 && !send_pause &&
			    (quiet || $urandom_range(99) >= 8)) begin
				access_t a;
				a = pending_words.pop_front();
				in_valid <= 1'b1;
				opcode <= a.op;
				address <= a.addr;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with one long hold counted here
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 8);
		end
	end

	// monitor: predict on acceptance, compare on result
	always @(posedge clk) begin
		outcome_t p, g;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				cache_access('{op: opcode, addr: address}, p);
				expected_results = {expected_results, p};
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				g = '{l1_hit, l2_hit, l1_evict, l2_evict, back_invalidate};
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result word", 1, 0);
				end else begin
					p = expected_results.pop_front();
					if (g.l1h !== p.l1h) report_mismatch("l1_hit", g.l1h, p.l1h);
					if (g.l2h !== p.l2h) report_mismatch("l2_hit", g.l2h, p.l2h);
					if (g.l1e !== p.l1e) report_mismatch("l1_evict", g.l1e, p.l1e);
					if (g.l2e !== p.l2e) report_mismatch("l2_evict", g.l2e, p.l2e);
					if (g.binv !== p.binv) report_mismatch("back_invalidate", g.binv, p.binv);
				end
			end
			if (moved) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("two_level_inclusive_cache_tags_tb NOT OK");
				$finish;
			end
		end
	end

	function automatic logic [31:0] make_addr(int tagv, int fset);
		return ((tagv << 8) | fset) << OFFB | $urandom_range(63);
	endfunction

	task automatic drain();
		while (pending_words.size() != 0 || expected_results.size() != 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_policy(bit val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		rand_policy = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random traffic: hot sets with many tags, plus broad noise
	task automatic queue_random(int n, int hot_tags);
		access_t a;
		for (int i = 0; i < n; i++) begin
			a.op = $urandom_range(1);
			if ($urandom_range(9) < 8)
				a.addr = make_addr($urandom_range(hot_tags - 1) * 3 + $urandom_range(1) * 1000,
					$urandom_range(3) * 64 + $urandom_range(1));
			else
				a.addr = $urandom;
			queue_word(a);
		end
	endtask

	initial begin
		quiet = 0; send_pause = 0;
		lfsr = tlic_pkg::LFSR_SEED; rand_policy = 0;
		foreach (n_val[i]) begin n_val[i] = 0; n_dty[i] = 0; n_age[i] = 0; n_tag[i] = 0; end
		foreach (f_val[i]) begin f_val[i] = 0; f_dty[i] = 0; f_age[i] = 0; f_tag[i] = 0; end
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_data = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		write_policy(1'b0);
		// directed: extremes, write hit, nine tags on one far set to force
		// far eviction of a dirty line
		queue_word('{tlic_pkg::OP_READ, 32'h0000_0000});
		queue_word('{tlic_pkg::OP_WRITE, 32'hFFFF_FFFF});
		queue_word('{tlic_pkg::OP_WRITE, 32'h0000_0000});
		queue_word('{tlic_pkg::OP_READ, 32'hFFFF_FFC0});
		for (int t = 1; t <= 9; t++) queue_word('{tlic_pkg::OP_WRITE, make_addr(t, 5)});
		queue_word('{tlic_pkg::OP_READ, make_addr(1, 5)});
		queue_word('{tlic_pkg::OP_READ, make_addr(2, 5)});
		queue_word('{tlic_pkg::OP_READ, 32'hAAAA_AAAA});
		queue_word('{tlic_pkg::OP_WRITE, 32'h5555_5555});
		drain();

		// long receiver hold while the sender keeps going
		quiet = 1;
		queue_random(300, 12);
		hold_req = 1;
		wait (hold_done && hold_cnt == 0);
		quiet = 0;
		queue_random(300, 12);
		drain();

		write_policy(1'b1);
		queue_random(500, 14);
		// sender pauses until everything has come back
		while (pending_words.size() > 250) @(posedge clk);
		send_pause = 1;
		while (expected_results.size() != 0 || in_valid) @(posedge clk);
		send_pause = 0;
		drain();

		write_policy(1'b0);
		queue_random(600, 10);
		drain();

		if (errors == 0)
			$display("two_level_inclusive_cache_tags_tb OK");
		else
			$display("two_level_inclusive_cache_tags_tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/tlic_pkg.sv
rtl/core/tlic_ram.sv
rtl/core/two_level_inclusive_cache_tags.sv
tb/sv/two_level_inclusive_cache_tags_tb.sv
